// ----- rtl/core/msw_pkg.sv -----
// Shared types and codes for the multi-slot watchdog.
package msw_pkg;

   // Command kinds on the request channel
   localparam logic [1:0] KIND_REQUEST = 2'd0;
   localparam logic [1:0] KIND_RELEASE = 2'd1;
   localparam logic [1:0] KIND_KICK    = 2'd2;
   localparam logic [1:0] KIND_TICK    = 2'd3;

   // Result status codes
   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_ZERO_REJ  = 2'd1;
   localparam logic [1:0] STATUS_NO_FREE   = 2'd2;
   localparam logic [1:0] STATUS_KICK_FREE = 2'd3;

   localparam int TICK_W     = 32;
   localparam int INTERVAL_W = 16;
   localparam int SLOT_W     = 4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REQ_SCAN,
      ST_TICK_SCAN,
      ST_DONE
   } msw_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;        // capture command, clear result and scan state
      logic reject_zero; // request with zero interval
      logic release_op;  // free the addressed slot
      logic kick_op;     // restamp the addressed slot
      logic tick_inc;    // advance tick count
      logic req_step;    // one slot of the free-slot search
      logic tick_step;   // one slot of the expiry scan
      logic push;        // move result into output register
   } msw_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [1:0] kind;
      logic       interval_zero;
      logic       free_here;
      logic       req_last;
      logic       hit;
      logic       scan_end;
      logic       out_free;
   } msw_stat_type;

endpackage

// ----- rtl/core/msw_if.sv -----
// Request and result channel interfaces of the multi-slot watchdog.
interface msw_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [3:0] slot;
   logic [15:0] interval;

   modport source (output valid, output kind, output slot, output interval, input ready);
   modport sink   (input valid, input kind, input slot, input interval, output ready);
endinterface

interface msw_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [3:0] granted_slot;
   logic       timed_out;
   logic [3:0] timed_out_slot;

   modport source (output valid, output status, output granted_slot, output timed_out,
                   output timed_out_slot, input ready);
   modport sink   (input valid, input status, input granted_slot, input timed_out,
                   input timed_out_slot, output ready);
endinterface

// ----- rtl/core/msw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module msw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/msw_ctrl.sv -----
// Sequencing state machine of the multi-slot watchdog.
module msw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  msw_pkg::msw_stat_type stat,
   output msw_pkg::msw_cmd_type  cmd
);
   import msw_pkg::*;

   msw_state_type state_ff;
   msw_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      in_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (stat.kind)
               KIND_REQUEST: begin
                  if (stat.interval_zero) begin
                     cmd.reject_zero = 1'b1;
                     state_in        = ST_DONE;
                  end else begin
                     state_in = ST_REQ_SCAN;
                  end
               end
               KIND_RELEASE: begin
                  cmd.release_op = 1'b1;
                  state_in       = ST_DONE;
               end
               KIND_KICK: begin
                  cmd.kick_op = 1'b1;
                  state_in    = ST_DONE;
               end
               default: begin
                  cmd.tick_inc = 1'b1;
                  state_in     = ST_TICK_SCAN;
               end
            endcase
         end
         ST_REQ_SCAN: begin
            cmd.req_step = 1'b1;
            if (stat.free_here || stat.req_last) begin
               state_in = ST_DONE;
            end
         end
         ST_TICK_SCAN: begin
            cmd.tick_step = 1'b1;
            if (stat.hit || stat.scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/core/msw_datapath.sv -----
// Slot storage, tick counter, scan logic and output register of the watchdog.
module msw_datapath #(
   parameter int SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  msw_pkg::msw_cmd_type  cmd,
   output msw_pkg::msw_stat_type stat,
   input  logic [1:0]            in_kind,
   input  logic [3:0]            in_slot,
   input  logic [15:0]           in_interval,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [1:0]            out_status,
   output logic [3:0]            out_granted_slot,
   output logic                  out_timed_out,
   output logic [3:0]            out_timed_out_slot
);
   import msw_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   // Captured command
   logic [1:0]            kind_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic [INTERVAL_W-1:0] interval_ff;

   // Watchdog state
   logic [TICK_W-1:0] tick_count_ff;
   logic [SLOTS-1:0]  used_ff;

   // Scan state
   logic [CNT_W-1:0] cnt_ff;
   logic             chk_vld_ff;
   logic [IDX_W-1:0] chk_idx_ff;

   // Pending result
   logic [1:0]        res_status_ff;
   logic [SLOT_W-1:0] res_granted_ff;
   logic              res_to_ff;
   logic [SLOT_W-1:0] res_to_slot_ff;

   // Output register
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [SLOT_W-1:0] rsp_granted_ff;
   logic              rsp_to_ff;
   logic [SLOT_W-1:0] rsp_to_slot_ff;

   logic [IDX_W-1:0]      cnt_idx;
   logic [IDX_W-1:0]      slot_idx;
   logic                  cnt_in_range;
   logic                  slot_in_range;
   logic                  free_here;
   logic                  kick_ok;
   logic                  hit;
   logic [TICK_W-1:0]     elapsed;
   logic                  ival_wr;
   logic                  stamp_wr;
   logic [IDX_W-1:0]      stamp_addr;
   logic                  rd_en;
   logic [INTERVAL_W-1:0] ival_rd;
   logic [TICK_W-1:0]     stamp_rd;

   assign cnt_idx       = cnt_ff[IDX_W-1:0];
   assign slot_idx      = IDX_W'(slot_ff);
   assign cnt_in_range  = (cnt_ff < CNT_W'(SLOTS));
   assign slot_in_range = (32'(slot_ff) < SLOTS);
   assign free_here     = cnt_in_range && !used_ff[cnt_idx];
   assign kick_ok       = cmd.kick_op && slot_in_range && used_ff[slot_idx];

   // Expiry check on data read in the previous cycle
   assign elapsed = tick_count_ff - stamp_rd;
   assign hit     = chk_vld_ff && (elapsed > TICK_W'(ival_rd));

   // RAM ports
   assign ival_wr    = cmd.req_step && free_here;
   assign stamp_wr   = ival_wr || kick_ok;
   assign stamp_addr = cmd.kick_op ? slot_idx : cnt_idx;
   assign rd_en      = cmd.tick_step && cnt_in_range;

   msw_ram #(.WIDTH(INTERVAL_W), .DEPTH(SLOTS)) u_ival_ram (
      .clock   (clock),
      .wr_en   (ival_wr),
      .wr_addr (cnt_idx),
      .wr_data (interval_ff),
      .rd_en   (rd_en),
      .rd_addr (cnt_idx),
      .rd_data (ival_rd)
   );

   msw_ram #(.WIDTH(TICK_W), .DEPTH(SLOTS)) u_stamp_ram (
      .clock   (clock),
      .wr_en   (stamp_wr),
      .wr_addr (stamp_addr),
      .wr_data (tick_count_ff),
      .rd_en   (rd_en),
      .rd_addr (cnt_idx),
      .rd_data (stamp_rd)
   );

   // Command capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff     <= in_kind;
         slot_ff     <= in_slot;
         interval_ff <= in_interval;
      end
   end

   // Tick counter and in-use bits
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
         used_ff       <= '0;
      end else begin
         if (cmd.tick_inc) begin
            tick_count_ff <= tick_count_ff + 1'b1;
         end
         if (ival_wr) begin
            used_ff[cnt_idx] <= 1'b1;
         end
         if (cmd.release_op && slot_in_range) begin
            used_ff[slot_idx] <= 1'b0;
         end
      end
   end

   // Scan counter and pending check
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         chk_vld_ff <= 1'b0;
      end else if (cmd.load) begin
         cnt_ff     <= '0;
         chk_vld_ff <= 1'b0;
      end else if (cmd.req_step) begin
         cnt_ff <= cnt_ff + 1'b1;
      end else if (cmd.tick_step) begin
         if (cnt_in_range) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         chk_vld_ff <= cnt_in_range && used_ff[cnt_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tick_step) begin
         chk_idx_ff <= cnt_idx;
      end
   end

   // Result assembly
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_status_ff  <= STATUS_DONE;
         res_granted_ff <= '0;
         res_to_ff      <= 1'b0;
         res_to_slot_ff <= '0;
      end else begin
         if (cmd.reject_zero) begin
            res_status_ff <= STATUS_ZERO_REJ;
         end
         if (cmd.kick_op && !kick_ok) begin
            res_status_ff <= STATUS_KICK_FREE;
         end
         if (cmd.req_step) begin
            if (free_here) begin
               res_granted_ff <= SLOT_W'(cnt_idx);
            end else if (stat.req_last) begin
               res_status_ff <= STATUS_NO_FREE;
            end
         end
         if (cmd.tick_step && hit) begin
            res_to_ff      <= 1'b1;
            res_to_slot_ff <= SLOT_W'(chk_idx_ff);
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (out_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_status_ff  <= res_status_ff;
         rsp_granted_ff <= res_granted_ff;
         rsp_to_ff      <= res_to_ff;
         rsp_to_slot_ff <= res_to_slot_ff;
      end
   end

   assign out_valid          = rsp_valid_ff;
   assign out_status         = rsp_status_ff;
   assign out_granted_slot   = rsp_granted_ff;
   assign out_timed_out      = rsp_to_ff;
   assign out_timed_out_slot = rsp_to_slot_ff;

   // Status to controller
   always_comb begin
      stat               = '0;
      stat.kind          = kind_ff;
      stat.interval_zero = (interval_ff == '0);
      stat.free_here     = free_here;
      stat.req_last      = (cnt_ff == CNT_W'(SLOTS - 1));
      stat.hit           = hit;
      stat.scan_end      = !cnt_in_range && !chk_vld_ff;
      stat.out_free      = !rsp_valid_ff || out_ready;
   end

endmodule

// ----- rtl/core/multi_slot_watchdog_top.sv -----
// Top level of the multi-slot watchdog: controller, datapath and channel hookup.
// Release, kick and a zero-interval request finish in the execute state; a request scans
// from slot 0 up to the lowest free slot, or through all SLOTS slots with none free.
// A tick runs the expiry scan, which reads one slot per cycle through the
// single read port of the interval and stamp RAMs. One item is in work at a time; the next
// is accepted once the result has entered the output register.
// Synchronous reset clears the tick count, the in-use bits and the output register.
module multi_slot_watchdog_top #(
   parameter int SLOTS = 16
) (
   input logic        clock,
   input logic        reset,
   msw_req_if.sink    req_ch,
   msw_rsp_if.source  rsp_ch
);
   import msw_pkg::*;

   msw_cmd_type  cmd;
   msw_stat_type stat;

   msw_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_ch.valid),
      .in_ready (req_ch.ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   msw_datapath #(.SLOTS(SLOTS)) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .in_kind            (req_ch.kind),
      .in_slot            (req_ch.slot),
      .in_interval        (req_ch.interval),
      .out_valid          (rsp_ch.valid),
      .out_ready          (rsp_ch.ready),
      .out_status         (rsp_ch.status),
      .out_granted_slot   (rsp_ch.granted_slot),
      .out_timed_out      (rsp_ch.timed_out),
      .out_timed_out_slot (rsp_ch.timed_out_slot)
   );

endmodule

// ----- rtl/core/msw_checker.sv -----
// Port-level assertions for the multi-slot watchdog and their bind.
module msw_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [3:0] rsp_granted_slot,
   input logic       rsp_timed_out,
   input logic [3:0] rsp_timed_out_slot
);
   import msw_pkg::*;

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!reset && rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

   // One item at a time: busy right after a transfer
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (!reset && req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous item in work");

   // A timeout report is a plain done result with no grant
   a_timeout_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_timed_out) |->
         (rsp_status == STATUS_DONE && rsp_granted_slot == 4'd0))
      else $error("timeout result with stray status or grant");

   // Slot fields are zero when they do not apply
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (!rsp_timed_out || rsp_status != STATUS_DONE)) |->
         (rsp_timed_out_slot == 4'd0 &&
          (rsp_status == STATUS_DONE || rsp_granted_slot == 4'd0)))
      else $error("slot field set on a result that carries none");

endmodule

bind multi_slot_watchdog_top msw_checker u_msw_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_status         (rsp_ch.status),
   .rsp_granted_slot   (rsp_ch.granted_slot),
   .rsp_timed_out      (rsp_ch.timed_out),
   .rsp_timed_out_slot (rsp_ch.timed_out_slot)
);

// ----- verif/tb_multi_slot_watchdog_top.sv -----
// Self-checking testbench for the multi-slot watchdog: directed command tests, then random traffic.
module tb_multi_slot_watchdog_top;
   import msw_pkg::*;

   localparam int SLOTS       = 16;
   localparam int TAIL_CYCLES = SLOTS + 8;
   localparam int LIMIT       = 400000;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] granted_slot;
      logic       timed_out;
      logic [3:0] timed_out_slot;
   } wd_result_type;

   logic clock;
   logic reset;

   msw_req_if req_ch ();
   msw_rsp_if rsp_ch ();

   multi_slot_watchdog_top #(
      .SLOTS(SLOTS)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // Watchdog state as predicted
   logic [31:0] wd_tick;
   logic [31:0] wd_stamp [SLOTS];
   logic [15:0] wd_interval [SLOTS];

   wd_result_type expected_rsp_q[$];
   int            mismatch_count;
   int            idle_pct;
   int            cycle_count;

   // Clock
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Work out the result of one command and advance the predicted state
   function automatic wd_result_type predict_cmd(input logic [1:0] kind, input logic [3:0] slot,
                                                 input logic [15:0] iv);
      wd_result_type r;
      logic [31:0]   age;
      r = '0;
      case (kind)
         KIND_REQUEST: begin
            if (iv == 16'd0) begin
               r.status = STATUS_ZERO_REJ;
            end else begin
               r.status = STATUS_NO_FREE;
               for (int i = 0; i < SLOTS; i++) begin
                  if (r.status == STATUS_NO_FREE && wd_interval[i] == 16'd0) begin
                     wd_interval[i] = iv;
                     wd_stamp[i]    = wd_tick;
                     r.status       = STATUS_DONE;
                     r.granted_slot = 4'(i);
                  end
               end
            end
         end
         KIND_RELEASE: begin
            wd_interval[slot] = 16'd0;
            wd_stamp[slot]    = 32'd0;
            r.status          = STATUS_DONE;
         end
         KIND_KICK: begin
            if (wd_interval[slot] != 16'd0) begin
               wd_stamp[slot] = wd_tick;
               r.status       = STATUS_DONE;
            end else begin
               r.status = STATUS_KICK_FREE;
            end
         end
         default: begin
            wd_tick = wd_tick + 32'd1;
            r.status = STATUS_DONE;
            for (int i = 0; i < SLOTS; i++) begin
               age = wd_tick - wd_stamp[i];
               if (!r.timed_out && wd_interval[i] != 16'd0 && age > 32'(wd_interval[i])) begin
                  r.timed_out      = 1'b1;
                  r.timed_out_slot = 4'(i);
               end
            end
         end
      endcase
      return r;
   endfunction

   // One command transfer; the expectation is queued when the block takes it
   task automatic send_cmd(input logic [1:0] kind, input logic [3:0] slot, input logic [15:0] iv);
      @(negedge clock);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.kind     <= kind;
      req_ch.slot     <= slot;
      req_ch.interval <= iv;
      do @(posedge clock); while (!req_ch.ready);
      expected_rsp_q.push_back(predict_cmd(kind, slot, iv));
      // drop valid so the same command is not taken twice
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   // Hold off until every outstanding result has come back
   task automatic wait_drained();
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input int exp_val, input int got_val);
      if (exp_val != got_val) begin
         $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_val, got_val);
         mismatch_count++;
      end
   endtask

   // Empty block: tick with nothing in use, zero interval, kick and release of free slots
   task automatic test_empty_block();
      send_cmd(KIND_TICK, 4'd0, 16'd0);
      send_cmd(KIND_REQUEST, 4'd0, 16'd0);
      send_cmd(KIND_KICK, 4'd5, 16'hFFFF);
      send_cmd(KIND_RELEASE, 4'd15, 16'd0);
   endtask

   // Claim every slot, then one request too many
   task automatic test_fill_slots();
      logic [15:0] iv;
      for (int i = 0; i < SLOTS; i++) begin
         case (i)
            0:       iv = 16'hFFFF;
            1:       iv = 16'h5555;
            2:       iv = 16'hAAAA;
            3:       iv = 16'd1;
            9:       iv = 16'd2;
            default: iv = 16'h8000 | 16'(i);
         endcase
         send_cmd(KIND_REQUEST, 4'(15 - i), iv);
      end
      send_cmd(KIND_REQUEST, 4'd0, 16'd1);
   endtask

   // Expiry order, kick of a live slot, release and regrant of the freed slot
   task automatic test_expiry();
      wait_drained();
      send_cmd(KIND_TICK, 4'd0, 16'd0);
      send_cmd(KIND_TICK, 4'd0, 16'd0);
      send_cmd(KIND_KICK, 4'd3, 16'd0);
      send_cmd(KIND_TICK, 4'd0, 16'd0);
      send_cmd(KIND_RELEASE, 4'd9, 16'd0);
      send_cmd(KIND_REQUEST, 4'd0, 16'd3);
   endtask

   // Random commands in phases with shifting mix and idling
   task automatic test_random_traffic();
      int          pick;
      int          req_w;
      int          rel_w;
      int          kick_w;
      logic [15:0] iv;
      logic [3:0]  slot;
      for (int phase = 0; phase < 7; phase++) begin
         idle_pct = (phase == 2 || phase == 6) ? 0 : 25;
         if (phase % 2 == 0) begin
            req_w = 35; rel_w = 10; kick_w = 25;
         end else begin
            req_w = 15; rel_w = 25; kick_w = 25;
         end
         for (int n = 0; n < 200; n++) begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
               0:       iv = 16'd0;
               1, 2:    iv = 16'($urandom_range(0, 65535));
               default: iv = 16'($urandom_range(1, 6));
            endcase
            // bias toward low slots, which requests fill first
            slot = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 5)) : 4'($urandom);
            if (pick < req_w) begin
               send_cmd(KIND_REQUEST, slot, iv);
            end else if (pick < req_w + rel_w) begin
               send_cmd(KIND_RELEASE, slot, iv);
            end else if (pick < req_w + rel_w + kick_w) begin
               send_cmd(KIND_KICK, slot, iv);
            end else begin
               send_cmd(KIND_TICK, slot, iv);
            end
         end
         wait_drained();
      end
   endtask

   // Result side: random stalls in bursts
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 6) - 1) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      wd_result_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t unexpected result: expected none, actual status %0d granted %0d %s",
                     $time, rsp_ch.status, rsp_ch.granted_slot,
                     $sformatf("timed_out %0d slot %0d", rsp_ch.timed_out,
                               rsp_ch.timed_out_slot));
            mismatch_count++;
         end else begin
            exp_r = expected_rsp_q.pop_front();
            check_field("status", exp_r.status, rsp_ch.status);
            check_field("granted_slot", exp_r.granted_slot, rsp_ch.granted_slot);
            check_field("timed_out", exp_r.timed_out, rsp_ch.timed_out);
            check_field("timed_out_slot", exp_r.timed_out_slot, rsp_ch.timed_out_slot);
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Test sequence
   initial begin
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.kind     = KIND_TICK;
      req_ch.slot     = 4'd0;
      req_ch.interval = 16'd0;
      mismatch_count  = 0;
      cycle_count     = 0;
      idle_pct        = 20;
      wd_tick         = 32'd0;
      for (int i = 0; i < SLOTS; i++) begin
         wd_stamp[i]    = 32'd0;
         wd_interval[i] = 16'd0;
      end
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      test_empty_block();
      test_fill_slots();
      test_expiry();
      test_random_traffic();

      @(negedge clock);
      req_ch.valid <= 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
